FILE: sv/csh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_pkg
// Shared types and constants of the closest sphere hit block.
// ----------------------------------------------------------------------------
package csh_pkg;

   localparam int MAX_SPHERES = 256;
   localparam int CNT_W = $clog2(MAX_SPHERES);

   localparam int CSR_ADDR_W = 3;
   localparam logic [30:0] MIN_DISTANCE_RESET = 31'd6554;
   localparam logic REG_MIN_DISTANCE = 1'b0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      KIND_RAY = 1'b0,
      KIND_SPHERE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [17:0] b_x;
      logic signed [17:0] b_y;
      logic signed [17:0] b_z;
      logic [30:0] sphere_radius;
      logic [30:0] start_distance;
      logic last;
   } item_type;

   typedef struct packed {
      logic valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CALC,
      ST_CHECK,
      ST_SQRT,
      ST_UPDATE,
      ST_OUT
   } state_type;

   localparam logic [3:0] STEP_BSAT = 4'd3;
   localparam logic [3:0] STEP_BB = 4'd4;
   localparam logic [3:0] STEP_RR = 4'd5;
   localparam logic [3:0] STEP_LAST = 4'd8;

endpackage

FILE: sv/csh_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_req_if
// Input channel: ray and sphere items.
// ----------------------------------------------------------------------------
interface csh_req_if;
   logic valid;
   logic ready;
   logic op;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [17:0] b_x;
   logic signed [17:0] b_y;
   logic signed [17:0] b_z;
   logic [30:0] sphere_radius;
   logic [30:0] start_distance;
   logic last;

   modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, sphere_radius,
                   start_distance, last, input ready);
   modport sink (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, sphere_radius,
                 start_distance, last, output ready);
endinterface

FILE: sv/csh_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_rsp_if
// Result channel: outcome of one ray search.
// ----------------------------------------------------------------------------
interface csh_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic [7:0] hit_index;
   logic [30:0] hit_distance;

   modport source (output valid, hit, hit_index, hit_distance, input ready);
   modport sink (input valid, hit, hit_index, hit_distance, output ready);
endinterface

FILE: sv/csh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_front
// Accepts items, tags them as ray or sphere and holds them in a short queue.
// ----------------------------------------------------------------------------
module csh_front
   import csh_pkg::*;
(
   input logic clock,
   input logic reset,
   csh_req_if.sink req,
   output queue_head_type head,
   input logic pop
);

   item_type q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0] count_ff, count_in;
   item_type new_item;
   logic push;
   logic do_pop;

   always_comb begin
      new_item.kind = req.op ? KIND_SPHERE : KIND_RAY;
      new_item.a_x = req.a_x;
      new_item.a_y = req.a_y;
      new_item.a_z = req.a_z;
      new_item.b_x = req.b_x;
      new_item.b_y = req.b_y;
      new_item.b_z = req.b_z;
      new_item.sphere_radius = req.sphere_radius;
      new_item.start_distance = req.start_distance;
      new_item.last = req.last;
   end

   assign req.ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push = req.valid && req.ready;
   assign do_pop = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: sv/csh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csh_back
// Sequencer: shared multiply-accumulate, bitwise square root, running best.
// ----------------------------------------------------------------------------
module csh_back
   import csh_pkg::*;
(
   input logic clock,
   input logic reset,
   input queue_head_type head,
   output logic pop,
   input logic [30:0] min_distance,
   csh_rsp_if.source rsp
);

   state_type state_ff, state_in;

   logic signed [31:0] origin_ff [3];
   logic signed [31:0] origin_in [3];
   logic signed [17:0] dir_ff [3];
   logic signed [17:0] dir_in [3];
   logic [30:0] best_ff, best_in;
   logic [CNT_W-1:0] best_idx_ff, best_idx_in;
   logic hit_ff, hit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   item_type cur_ff, cur_in;
   logic signed [31:0] d_ff [3];
   logic signed [31:0] d_in [3];
   logic [3:0] step_ff, step_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [31:0] b_ff, b_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;

   logic out_valid_ff, out_valid_in;
   logic out_hit_ff, out_hit_in;
   logic [7:0] out_index_ff, out_index_in;
   logic [30:0] out_dist_ff, out_dist_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic signed [65:0] acc_sh;
   logic signed [31:0] a_sel [3];
   logic [63:0] trial;
   logic signed [33:0] root;
   logic [30:0] new_best;

   function automatic logic signed [31:0] sat_diff(logic signed [31:0] a,
                                                   logic signed [31:0] o);
      logic signed [32:0] diff;
      diff = {a[31], a} - {o[31], o};
      if (diff[32] != diff[31]) begin
         return diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return diff[31:0];
   endfunction

   assign a_sel[0] = cur_ff.a_x;
   assign a_sel[1] = cur_ff.a_y;
   assign a_sel[2] = cur_ff.a_z;
   assign prod = mul_a * mul_b;
   assign acc_sh = acc_ff >>> 16;
   assign trial = res_ff + bit_ff;
   assign root = {{2{b_ff[31]}}, b_ff} - {2'b00, res_ff[31:0]};

   assign rsp.valid = out_valid_ff;
   assign rsp.hit = out_hit_ff;
   assign rsp.hit_index = out_index_ff;
   assign rsp.hit_distance = out_dist_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         4'd0: begin
            mul_a = 33'(dir_ff[0]);
            mul_b = 33'(d_ff[0]);
         end
         4'd1: begin
            mul_a = 33'(dir_ff[1]);
            mul_b = 33'(d_ff[1]);
         end
         4'd2: begin
            mul_a = 33'(dir_ff[2]);
            mul_b = 33'(d_ff[2]);
         end
         STEP_BB: begin
            mul_a = 33'(b_ff);
            mul_b = 33'(b_ff);
         end
         STEP_RR: begin
            mul_a = $signed({2'b00, cur_ff.sphere_radius});
            mul_b = $signed({2'b00, cur_ff.sphere_radius});
         end
         4'd6: begin
            mul_a = 33'(d_ff[0]);
            mul_b = 33'(d_ff[0]);
         end
         4'd7: begin
            mul_a = 33'(d_ff[1]);
            mul_b = 33'(d_ff[1]);
         end
         4'd8: begin
            mul_a = 33'(d_ff[2]);
            mul_b = 33'(d_ff[2]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      new_best = best_ff;
      if (root > $signed({3'b000, min_distance}) && root < $signed({3'b000, best_ff})) begin
         new_best = root[30:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      origin_in = origin_ff;
      dir_in = dir_ff;
      best_in = best_ff;
      best_idx_in = best_idx_ff;
      hit_in = hit_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      d_in = d_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      b_in = b_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_hit_in = out_hit_ff;
      out_index_in = out_index_ff;
      out_dist_in = out_dist_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.item.kind == KIND_RAY) begin
                  origin_in[0] = head.item.a_x;
                  origin_in[1] = head.item.a_y;
                  origin_in[2] = head.item.a_z;
                  dir_in[0] = head.item.b_x;
                  dir_in[1] = head.item.b_y;
                  dir_in[2] = head.item.b_z;
                  best_in = head.item.start_distance;
                  best_idx_in = '0;
                  hit_in = 1'b0;
                  cnt_in = '0;
               end else begin
                  cur_in = head.item;
                  idx_in = cnt_ff;
                  cnt_in = (cnt_ff == CNT_W'(MAX_SPHERES - 1)) ? '0 : CNT_W'(cnt_ff + 1'b1);
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               d_in[k] = sat_diff(a_sel[k], origin_ff[k]);
            end
            step_in = '0;
            acc_in = '0;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BSAT) begin
               if (acc_sh[65:31] != {35{acc_sh[65]}}) begin
                  b_in = acc_sh[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  b_in = acc_sh[31:0];
               end
               acc_in = '0;
            end else if (step_ff > STEP_RR) begin
               acc_in = acc_ff - prod;
            end else begin
               acc_in = acc_ff + prod;
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rem_in = {1'b0, acc_ff[62:0]};
            res_in = '0;
            bit_in = 64'h4000_0000_0000_0000;
            if (acc_ff[65]) begin
               state_in = cur_ff.last ? ST_OUT : ST_IDLE;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            best_in = new_best;
            if (root == $signed({3'b000, new_best})) begin
               best_idx_in = idx_ff;
               hit_in = 1'b1;
            end
            state_in = cur_ff.last ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               out_hit_in = hit_ff;
               out_index_in = hit_ff ? 8'(best_idx_ff) : 8'd0;
               out_dist_in = best_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '{default: '0};
         dir_ff <= '{default: '0};
         best_ff <= '0;
         best_idx_ff <= '0;
         hit_ff <= 1'b0;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         origin_ff <= origin_in;
         dir_ff <= dir_in;
         best_ff <= best_in;
         best_idx_ff <= best_idx_in;
         hit_ff <= hit_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      d_ff <= d_in;
      step_ff <= step_in;
      acc_ff <= acc_in;
      b_ff <= b_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      out_hit_ff <= out_hit_in;
      out_index_ff <= out_index_in;
      out_dist_ff <= out_dist_in;
   end

endmodule

FILE: sv/closest_sphere_hit.sv
`timescale 1ns / 1ps
// Sequence: a sphere item passes through the queue, the difference step, the shared
// multiplier, the check, the square root, the update and, when marked last, the
// output; a missed sphere skips the square root and update. A ray item is absorbed.
// Spheres are processed one at a time, paced by the 32-step square root and the
// single shared 33x33 multiplier. Reset is synchronous: ray state, search state
// and queue clear, min_distance returns to 6554.
// ----------------------------------------------------------------------------
// closest_sphere_hit
// Closest ray/sphere intersection search in Q16.16 with an APB register port.
// ----------------------------------------------------------------------------
module closest_sphere_hit
   import csh_pkg::*;
(
   input logic clock,
   input logic reset,
   csh_req_if.sink req,
   csh_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic [30:0] min_dist_ff, min_dist_in;
   queue_head_type head;
   logic pop;
   logic sel_min;

   assign sel_min = (csr_paddr[2] == REG_MIN_DISTANCE);
   assign csr_pready = 1'b1;
   assign csr_prdata = sel_min ? {1'b0, min_dist_ff} : 32'd0;

   always_comb begin
      min_dist_in = min_dist_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_min) begin
         min_dist_in = csr_pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= MIN_DISTANCE_RESET;
      end else begin
         min_dist_ff <= min_dist_in;
      end
   end

   csh_front u_front (
      .clock(clock),
      .reset(reset),
      .req(req),
      .head(head),
      .pop(pop)
   );

   csh_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .pop(pop),
      .min_distance(min_dist_ff),
      .rsp(rsp)
   );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Closest sphere hit check: ray and sphere items with random pacing on both
// channels, min_distance settings from zero to full scale, and an in-bench
// predictor of the search result for each sphere marked last.
// ----------------------------------------------------------------------------

class hit_scoreboard;
   logic [30:0] min_dist;
   logic signed [63:0] org [3];
   logic signed [63:0] dir [3];
   logic signed [63:0] best;
   logic [7:0] best_idx;
   logic found;
   logic [7:0] counter;
   logic [39:0] pending_hits [$];
   int errors;

   function new();
      min_dist = 31'd6554;
      for (int i = 0; i < 3; i++) begin
         org[i] = 0;
         dir[i] = 0;
      end
      best = 0;
      best_idx = 0;
      found = 0;
      counter = 0;
      errors = 0;
   endfunction

   function automatic logic signed [63:0] sat32(logic signed [63:0] x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] sq(logic signed [63:0] x);
      logic [63:0] a;
      a = (x < 0) ? -x : x;
      return a * a;
   endfunction

   function void note_item(csh_pkg::item_type it);
      logic signed [63:0] d [3];
      logic signed [127:0] braw;
      logic signed [63:0] b, root;
      logic [63:0] dd, pos;
      logic [7:0] idx;
      if (it.kind == csh_pkg::KIND_RAY) begin
         org[0] = it.a_x; org[1] = it.a_y; org[2] = it.a_z;
         dir[0] = it.b_x; dir[1] = it.b_y; dir[2] = it.b_z;
         best = {33'd0, it.start_distance};
         best_idx = 0;
         found = 0;
         counter = 0;
         return;
      end
      idx = counter;
      counter = counter + 8'd1;
      d[0] = sat32(64'(it.a_x) - org[0]);
      d[1] = sat32(64'(it.a_y) - org[1]);
      d[2] = sat32(64'(it.a_z) - org[2]);
      braw = 0;
      dd = 0;
      for (int i = 0; i < 3; i++) begin
         braw = braw + 128'(dir[i]) * 128'(d[i]);
         dd = dd + sq(d[i]);
      end
      b = sat32(64'(braw >>> 16));
      pos = sq(b) + {33'd0, it.sphere_radius} * {33'd0, it.sphere_radius};
      if (dd <= pos) begin
         root = b - $signed(isqrt(pos - dd));
         if (root > $signed({33'd0, min_dist}) && root < best) best = root;
         if (root == best) begin
            best_idx = idx;
            found = 1;
         end
      end
      if (it.last)
         pending_hits.push_back({found, found ? best_idx : 8'd0, best[30:0]});
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_result(logic h, logic [7:0] hi, logic [30:0] hd);
      logic [39:0] e;
      if (pending_hits.size() == 0) begin
         report("result with none expected");
         return;
      end
      e = pending_hits.pop_front();
      if (h !== e[39]) report($sformatf("hit %0b want %0b", h, e[39]));
      if (hi !== e[38:31]) report($sformatf("hit_index %0d want %0d", hi, e[38:31]));
      if (hd !== e[30:0]) report($sformatf("hit_distance %0d want %0d", hd, e[30:0]));
   endtask
endclass

module testbench;
   import csh_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int idle_cycles = 0;
   int stall_phase = 0;
   hit_scoreboard board;

   csh_req_if req ();
   csh_rsp_if rsp ();

   closest_sphere_hit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req.valid = 0; req.op = 0; req.last = 0;
      req.a_x = 0; req.a_y = 0; req.a_z = 0;
      req.b_x = 0; req.b_y = 0; req.b_z = 0;
      req.sphere_radius = 0; req.start_distance = 0;
      rsp.ready = 0;
   end

   // receiver stalls on a repeating pattern with random slack
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 64;
      if (stall_phase < 20) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_result(rsp.hit, rsp.hit_index, rsp.hit_distance);
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task write_min_distance(logic [30:0] v);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_W'({REG_MIN_DISTANCE, 2'b00}); csr_pwdata <= {1'b0, v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.min_dist = v;
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task send_item(item_type it);
      req.valid <= 1;
      req.op <= it.kind; req.last <= it.last;
      req.a_x <= it.a_x; req.a_y <= it.a_y; req.a_z <= it.a_z;
      req.b_x <= it.b_x; req.b_y <= it.b_y; req.b_z <= it.b_z;
      req.sphere_radius <= it.sphere_radius; req.start_distance <= it.start_distance;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_item(it);
   endtask

   task pause(int n);
      req.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task drain();
      pause(1);
      while (board.pending_hits.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'sh8000_0000 + $urandom_range(0, 3);
         2: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
      endcase
   endfunction

   function automatic item_type make_ray(int mode);
      item_type it;
      int m;
      it = '0;
      it.kind = KIND_RAY;
      m = (mode == 0) ? 3 : $urandom_range(0, 3);
      it.a_x = rand_coord(m); it.a_y = rand_coord(m); it.a_z = rand_coord(m);
      it.b_x = $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
      it.b_y = $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
      it.b_z = $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
      if ($urandom_range(0, 3) == 0) it.b_x = 18'sh20000 | 18'($urandom);
      it.start_distance = ($urandom_range(0, 4) == 0) ? 31'($urandom) :
                          31'($urandom_range(1 << 16, 200 << 16));
      it.last = 1'($urandom);
      return it;
   endfunction

   function automatic item_type make_sphere(int mode, logic lst, const ref item_type ray);
      item_type it;
      it = '0;
      it.kind = KIND_SPHERE;
      if (mode == 0) begin
         it.a_x = ray.a_x + 32'($signed(ray.b_x) * $signed(32'($urandom_range(1, 80))));
         it.a_y = ray.a_y + 32'($signed(ray.b_y) * $signed(32'($urandom_range(1, 80))));
         it.a_z = ray.a_z + 32'($signed(ray.b_z) * $signed(32'($urandom_range(1, 80))));
         it.sphere_radius = 31'($urandom_range(0, 30 << 16));
      end else begin
         it.a_x = rand_coord(mode % 4); it.a_y = rand_coord(mode % 4);
         it.a_z = rand_coord(mode % 4);
         it.sphere_radius = ($urandom_range(0, 1)) ? 31'($urandom) :
                            31'($urandom_range(0, 30 << 16));
      end
      it.b_x = 18'($urandom); it.b_y = 18'($urandom); it.b_z = 18'($urandom);
      it.start_distance = 31'($urandom);
      it.last = lst;
      return it;
   endfunction

   initial begin
      item_type ray, sp;
      int sent, n, burst;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: spheres before any ray, extremes, tangent and wrap cases
      sp = '0; sp.kind = KIND_SPHERE; sp.sphere_radius = 31'h7FFF_FFFF; sp.last = 1;
      send_item(sp);
      sp.a_x = 32'sh8000_0000; sp.a_y = 32'sh7FFF_FFFF; sp.a_z = 32'sh8000_0000;
      send_item(sp);
      ray = '0; ray.kind = KIND_RAY; ray.b_x = 18'sd65536; ray.last = 1;
      ray.start_distance = 31'h7FFF_FFFF;
      send_item(ray);
      sp = '0; sp.kind = KIND_SPHERE; sp.a_x = 10 << 16; sp.sphere_radius = 1 << 16;
      send_item(sp);
      send_item(sp);
      sp.a_x = 5 << 16; sp.sphere_radius = 0; sp.last = 1;
      send_item(sp);
      sp.a_x = 32'sh7FFF_FFFF; sp.sphere_radius = 31'h7FFF_FFFF;
      send_item(sp);
      ray.a_x = 32'sh8000_0000; ray.a_y = 32'sh7FFF_FFFF; ray.a_z = 32'sh8000_0000;
      ray.b_x = -18'sd65536; ray.b_y = 18'sh1FFFF; ray.b_z = 18'sh20000;
      send_item(ray);
      sp = make_sphere(1, 1, ray); send_item(sp);
      sp = make_sphere(2, 1, ray); send_item(sp);
      drain();
      write_min_distance(31'd0);
      ray = make_ray(0); ray.b_x = 0; ray.b_y = 0; ray.b_z = 0; ray.start_distance = 0;
      send_item(ray);
      sp = '0; sp.kind = KIND_SPHERE; sp.a_x = ray.a_x; sp.a_y = ray.a_y; sp.a_z = ray.a_z;
      sp.last = 1;
      send_item(sp);
      drain();
      write_min_distance(31'h7FFF_FFFF);
      ray = make_ray(0); send_item(ray);
      sp = make_sphere(0, 1, ray); send_item(sp);
      drain();
      write_min_distance(31'd6554);
      ray = make_ray(0); send_item(ray);
      for (int i = 0; i < 258; i++) begin
         sp = make_sphere(0, i == 257, ray);
         send_item(sp);
      end
      drain();

      sent = 0;
      while (sent < 1200) begin
         if ($urandom_range(0, 5) == 0) begin
            drain();
            case ($urandom_range(0, 3))
               0: write_min_distance(31'd0);
               1: write_min_distance(31'h7FFF_FFFF);
               default: write_min_distance(31'($urandom_range(0, 2 << 16)));
            endcase
         end
         ray = make_ray($urandom_range(0, 4) == 0);
         send_item(ray);
         sent++;
         n = $urandom_range(1, 8);
         burst = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) begin
            if (--burst == 0) begin
               burst = $urandom_range(1, 6);
               if ($urandom_range(0, 1)) pause($urandom_range(1, 50));
            end
            sp = make_sphere(($urandom_range(0, 4) < 3) ? 0 : $urandom_range(1, 3),
                             (i == n - 1) || ($urandom_range(0, 9) == 0), ray);
            send_item(sp);
            sent++;
         end
      end
      drain();
      if (board.pending_hits.size() == 0 && board.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
